// File: rtl/core/rdx_pkg.sv
// Shared types and constants for the readability index counter.
// Depends on nothing; every module of the block imports it.
package rdx_pkg;

  // Default counter width for the letter, whitespace and mark totals.
  localparam int RDX_COUNT_BITS = 16;

  // Weights of the index in hundredths: 588*L - 2960*S - 1580*W over 100*W.
  localparam int RDX_LETTER_WT = 588;
  localparam int RDX_MARK_WT   = 2960;
  localparam int RDX_WORD_WT   = 1580;
  localparam int RDX_DEN_WT    = 100;

  // Saturation limits of the 22-bit signed index.
  localparam int RDX_INDEX_W   = 22;
  localparam int RDX_INDEX_MAX = 2097151;
  localparam int RDX_INDEX_MIN_MAG = 2097152;

  // Grade band thresholds.
  localparam int RDX_TOP_GRADE = 16;
  localparam int RDX_PRE_GRADE = 1;

  // Sentence marks.
  localparam logic [7:0] MARK_PERIOD   = 8'h2E;
  localparam logic [7:0] MARK_QUESTION = 8'h3F;
  localparam logic [7:0] MARK_BANG     = 8'h21;

  // Grade band codes.
  typedef enum logic [1:0] {
    BAND_PRE   = 2'd0,
    BAND_GRADE = 2'd1,
    BAND_TOP   = 2'd2
  } band_t;

  // One byte of the passage.
  typedef struct packed {
    logic [7:0] char_code;
    logic       final_char;
  } in_item_t;

  // One result per passage.
  typedef struct packed {
    logic signed [21:0] reading_index;
    logic [1:0]         grade_band;
    logic [3:0]         grade_level;
  } out_item_t;

  // Status of the passage queue, seen by both the front end and the arithmetic back end.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// File: rtl/core/rdx_front.sv
// Front end: accepts passage bytes, classifies them and keeps saturating totals.
// Depends on rdx_pkg; pushes finished passage totals into rdx_fifo.
module rdx_front
  import rdx_pkg::*;
#(
  parameter int COUNT_BITS = RDX_COUNT_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  in_item_t                  in_data,
  input  q_status_t                 q_status,
  output logic                      push,
  output logic [3*COUNT_BITS-1:0]   push_data
);

  logic [COUNT_BITS-1:0] ltr_r, ltr_nxt;
  logic [COUNT_BITS-1:0] spc_r, spc_nxt;
  logic [COUNT_BITS-1:0] mrk_r, mrk_nxt;
  logic [COUNT_BITS-1:0] ltr_bump, spc_bump, mrk_bump;
  logic                  accept;
  logic                  is_letter, is_space, is_mark;

  // Bytes are taken whenever the queue has room for a finished passage.
  assign in_ready = ~q_status.full;
  assign accept   = in_valid & in_ready;
  assign push     = accept & in_data.final_char;

  // Classify the byte; bytes above 0x7F match nothing.
  always_comb begin
    is_letter = in_data.char_code inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    is_space  = in_data.char_code inside {8'h20, [8'h09:8'h0D]};
    is_mark   = in_data.char_code inside {MARK_PERIOD, MARK_QUESTION, MARK_BANG};
  end

  // Saturating increments of the totals that this byte touches.
  always_comb begin
    ltr_bump = ltr_r;
    spc_bump = spc_r;
    mrk_bump = mrk_r;
    if (is_letter && (ltr_r != '1)) begin
      ltr_bump = ltr_r + 1'b1;
    end
    if (is_space && (spc_r != '1)) begin
      spc_bump = spc_r + 1'b1;
    end
    if (is_mark && (mrk_r != '1)) begin
      mrk_bump = mrk_r + 1'b1;
    end
  end

  // The final byte is counted, the totals go to the queue and then clear.
  assign push_data = {ltr_bump, spc_bump, mrk_bump};

  always_comb begin
    ltr_nxt = ltr_r;
    spc_nxt = spc_r;
    mrk_nxt = mrk_r;
    if (push) begin
      ltr_nxt = '0;
      spc_nxt = '0;
      mrk_nxt = '0;
    end else if (accept) begin
      ltr_nxt = ltr_bump;
      spc_nxt = spc_bump;
      mrk_nxt = mrk_bump;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ltr_r <= '0;
      spc_r <= '0;
      mrk_r <= '0;
    end else begin
      ltr_r <= ltr_nxt;
      spc_r <= spc_nxt;
      mrk_r <= mrk_nxt;
    end
  end

endmodule

// File: rtl/core/rdx_fifo.sv
// Two-entry queue of passage totals between the front and back ends.
// Depends on rdx_pkg for the status struct.
module rdx_fifo
  import rdx_pkg::*;
#(
  parameter int WIDTH = 3 * RDX_COUNT_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output q_status_t        q_status
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign q_status.full  = (cnt_r == 2'd2);
  assign q_status.empty = (cnt_r == 2'd0);
  assign do_push  = push & ~q_status.full;
  assign do_pop   = pop & ~q_status.empty;
  assign pop_data = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: rtl/core/rdx_back.sv
// Back end: turns one passage's totals into the rounded index and grade band.
// Depends on rdx_pkg; a restoring divider yields one quotient bit per cycle.
module rdx_back
  import rdx_pkg::*;
#(
  parameter int COUNT_BITS = RDX_COUNT_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  q_status_t               q_status,
  output logic                    pop,
  input  logic [3*COUNT_BITS-1:0] pop_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output out_item_t               out_data
);

  localparam int WW  = COUNT_BITS + 1;   // words
  localparam int PLW = COUNT_BITS + 10;  // 588 * letters
  localparam int PSW = COUNT_BITS + 12;  // 2960 * marks
  localparam int PWW = COUNT_BITS + 12;  // 1580 * words
  localparam int DNW = COUNT_BITS + 7;   // 100 * words
  localparam int NW  = COUNT_BITS + 14;  // signed numerator
  localparam int MW  = NW - 1;           // numerator magnitude
  localparam int QW  = NW;               // dividend and quotient
  localparam int DW  = DNW + 1;          // divisor, twice the denominator
  localparam int CW  = $clog2(QW + 1);
  localparam int XW  = (QW > RDX_INDEX_W + 1) ? QW : RDX_INDEX_W + 1;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_SUM  = 6'b000100,
    ST_PREP = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_FIN  = 6'b100000
  } state_t;

  state_t                st_r, st_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;

  logic [COUNT_BITS-1:0] ltr_r, spc_r, mrk_r;
  logic [PLW-1:0]        p_l_r;
  logic [PSW-1:0]        p_s_r;
  logic [PWW-1:0]        p_w_r;
  logic [DNW-1:0]        den_r;
  logic signed [NW-1:0]  num_r;
  logic                  neg_r;
  logic [QW-1:0]         quo_r, quo_nxt;
  logic [DW-1:0]         rem_r, rem_nxt;
  logic [DW-1:0]         dsr_r;

  logic [WW-1:0]         words;
  logic [MW-1:0]         mag;
  logic [DW:0]           shifted;
  logic                  ge;
  logic                  load_out;
  logic [XW-1:0]         q_ext;
  logic [RDX_INDEX_W-1:0] idx;

  assign pop       = (st_r == ST_IDLE) & ~q_status.empty;
  assign load_out  = (st_r == ST_FIN) & (~out_valid_r | out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign words     = WW'(spc_r) + WW'(1);

  // Sequencer: fetch, weight, sum, prepare, divide, deliver.
  always_comb begin
    st_nxt  = st_r;
    cnt_nxt = cnt_r;
    case (st_r)
      ST_IDLE: begin
        if (pop) begin
          st_nxt = ST_MUL;
        end
      end
      ST_MUL:  st_nxt = ST_SUM;
      ST_SUM:  st_nxt = ST_PREP;
      ST_PREP: begin
        st_nxt  = ST_DIV;
        cnt_nxt = CW'(QW);
      end
      ST_DIV: begin
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          st_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (load_out) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Magnitude of the numerator.
  always_comb begin
    if (num_r[NW-1]) begin
      mag = MW'(-num_r);
    end else begin
      mag = MW'(num_r);
    end
  end

  // One restoring division step.
  always_comb begin
    shifted = {rem_r, quo_r[QW-1]};
    ge      = (shifted >= {1'b0, dsr_r});
    if (ge) begin
      rem_nxt = DW'(shifted - {1'b0, dsr_r});
    end else begin
      rem_nxt = shifted[DW-1:0];
    end
    quo_nxt = {quo_r[QW-2:0], ge};
  end

  // Saturate the signed quotient and pick the grade band.
  always_comb begin
    q_ext = XW'(quo_r);
    if (neg_r) begin
      if (q_ext > XW'(RDX_INDEX_MIN_MAG)) begin
        idx = RDX_INDEX_W'(RDX_INDEX_MIN_MAG);
      end else begin
        idx = RDX_INDEX_W'(-q_ext);
      end
    end else begin
      if (q_ext > XW'(RDX_INDEX_MAX)) begin
        idx = RDX_INDEX_W'(RDX_INDEX_MAX);
      end else begin
        idx = q_ext[RDX_INDEX_W-1:0];
      end
    end
    out_data_nxt.reading_index = idx;
    if ($signed(idx) >= $signed(RDX_INDEX_W'(RDX_TOP_GRADE))) begin
      out_data_nxt.grade_band  = BAND_TOP;
      out_data_nxt.grade_level = 4'd0;
    end else if ($signed(idx) <= $signed(RDX_INDEX_W'(RDX_PRE_GRADE))) begin
      out_data_nxt.grade_band  = BAND_PRE;
      out_data_nxt.grade_level = 4'd0;
    end else begin
      out_data_nxt.grade_band  = BAND_GRADE;
      out_data_nxt.grade_level = idx[3:0];
    end
  end

  // Output register holds a result until it is transferred.
  always_comb begin
    out_valid_nxt = out_valid_r & ~out_ready;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (pop) begin
      {ltr_r, spc_r, mrk_r} <= pop_data;
    end
    if (st_r == ST_MUL) begin
      p_l_r <= PLW'(ltr_r) * PLW'(RDX_LETTER_WT);
      p_s_r <= PSW'(mrk_r) * PSW'(RDX_MARK_WT);
      p_w_r <= PWW'(words) * PWW'(RDX_WORD_WT);
      den_r <= DNW'(words) * DNW'(RDX_DEN_WT);
    end
    if (st_r == ST_SUM) begin
      num_r <= $signed(NW'(p_l_r)) - $signed(NW'(p_s_r)) - $signed(NW'(p_w_r));
    end
    if (st_r == ST_PREP) begin
      neg_r <= num_r[NW-1];
      quo_r <= QW'({mag, 1'b0}) + QW'(den_r);
      rem_r <= '0;
      dsr_r <= {den_r, 1'b0};
    end
    if (st_r == ST_DIV) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
    if (load_out) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

// File: rtl/core/readability_index_counter.sv
// Top level of the readability index counter: front end, queue and back end.
// Depends on rdx_pkg, rdx_front, rdx_fifo and rdx_back.
//
// The block takes one passage byte per cycle and keeps saturating totals of
// letters, whitespace bytes and sentence marks, COUNT_BITS wide each. On the
// byte flagged final, the totals go into a two-entry queue and the counters
// clear, so the next passage starts from zero totals. The back end works on
// one passage at a time: it takes the totals from the queue, weights them,
// sums them, sets up the divider, runs a restoring divider that yields one
// quotient bit per cycle, and loads the output register once that register
// is free or being emptied. It takes the next passage only after the result
// is loaded. Bytes stall only when two finished passages are already waiting
// in the queue. The result is the Coleman-Liau index rounded to the nearest
// integer, ties away from zero, saturated to 22 bits signed, with its grade
// band.
module readability_index_counter
  import rdx_pkg::*;
#(
  parameter int COUNT_BITS = RDX_COUNT_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic                    push, pop;
  logic [3*COUNT_BITS-1:0] push_data, pop_data;
  q_status_t               q_status;

  // Byte intake and counting.
  rdx_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  // Queue of finished passage totals.
  rdx_fifo #(
    .WIDTH (3 * COUNT_BITS)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_status  (q_status)
  );

  // Index arithmetic and result register.
  rdx_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_status  (q_status),
    .pop       (pop),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: sim/tb_readability_index_counter.sv
// Self-checking testbench for readability_index_counter: passages go in one byte per transfer.
// A scoreboard class predicts the rounded Coleman-Liau index and grade band of each passage.
// Depends on rdx_pkg and the readability_index_counter RTL.
import rdx_pkg::*;

// Kinds of byte that the stimulus draws from.
typedef enum int {
  KIND_LETTER,
  KIND_SPACE,
  KIND_MARK,
  KIND_ANY
} byte_kind_t;

// Keeps its own letter, whitespace and mark totals and the results still owed.
class passage_scoreboard;
  longint      letters;
  longint      spaces;
  longint      marks;
  out_item_t   expected_q[$];
  int          failures;

  function new();
    letters   = 0;
    spaces    = 0;
    marks     = 0;
    failures  = 0;
  endfunction

  function int outstanding();
    return expected_q.size();
  endfunction

  // Saturating increment at the counter width of the block.
  function longint bump(longint v);
    longint top;
    top = (longint'(1) << RDX_COUNT_BITS) - 1;
    return (v < top) ? v + 1 : v;
  endfunction

  // Index in whole units, rounded half away from zero and clamped to 22 bits signed.
  function longint passage_index();
    longint w, num, den, mag, q, r;
    w   = spaces + 1;
    num = RDX_LETTER_WT * letters - RDX_MARK_WT * marks - RDX_WORD_WT * w;
    den = RDX_DEN_WT * w;
    mag = (num < 0) ? -num : num;
    q   = (2 * mag + den) / (2 * den);
    r   = (num < 0) ? -q : q;
    if (r > RDX_INDEX_MAX) r = RDX_INDEX_MAX;
    if (r < -longint'(RDX_INDEX_MIN_MAG)) r = -longint'(RDX_INDEX_MIN_MAG);
    return r;
  endfunction

  // Count one accepted byte; the final byte closes the passage and owes a result.
  function void note_byte(in_item_t item);
    logic [7:0] c;
    longint     idx;
    out_item_t  want;
    c = item.char_code;
    if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) begin
      letters = bump(letters);
    end else if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) begin
      spaces = bump(spaces);
    end else if (c == MARK_PERIOD || c == MARK_QUESTION || c == MARK_BANG) begin
      marks = bump(marks);
    end
    if (item.final_char) begin
      idx = passage_index();
      want.reading_index = idx[21:0];
      if (idx >= RDX_TOP_GRADE) begin
        want.grade_band  = BAND_TOP;
        want.grade_level = 4'd0;
      end else if (idx <= RDX_PRE_GRADE) begin
        want.grade_band  = BAND_PRE;
        want.grade_level = 4'd0;
      end else begin
        want.grade_band  = BAND_GRADE;
        want.grade_level = idx[3:0];
      end
      expected_q.push_back(want);
      letters = 0;
      spaces  = 0;
      marks   = 0;
    end
  endfunction

  // Compare one accepted result against the oldest prediction.
  function void check_result(out_item_t got);
    out_item_t want;
    if (expected_q.size() == 0) begin
      $display("%0t: result with none predicted: index %0d band %0d level %0d",
               $time, $signed(got.reading_index), got.grade_band, got.grade_level);
      failures++;
      return;
    end
    want = expected_q.pop_front();
    if (got.reading_index !== want.reading_index) begin
      $display("%0t: reading_index expected %0d, actual %0d", $time,
               $signed(want.reading_index), $signed(got.reading_index));
      failures++;
    end
    if (got.grade_band !== want.grade_band) begin
      $display("%0t: grade_band expected %0d, actual %0d", $time,
               want.grade_band, got.grade_band);
      failures++;
    end
    if (got.grade_level !== want.grade_level) begin
      $display("%0t: grade_level expected %0d, actual %0d", $time,
               want.grade_level, got.grade_level);
      failures++;
    end
  endfunction
endclass

module tb_readability_index_counter;
  localparam int CLK_PERIOD   = 12;
  localparam int DRAIN_CYCLES = RDX_COUNT_BITS + 40;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  passage_scoreboard sb;
  int send_idle;
  int recv_stall;
  int bytes_sent;

  readability_index_counter dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(CLK_PERIOD * 1500000);
    $display("readability_index_counter verification failed");
    $finish;
  end

  function automatic logic [7:0] pick_byte(byte_kind_t kind);
    int r;
    case (kind)
      KIND_LETTER: begin
        r = $urandom_range(0, 51);
        return (r < 26) ? 8'("A" + r) : 8'("a" + r - 26);
      end
      KIND_SPACE: begin
        r = $urandom_range(0, 5);
        return (r == 5) ? 8'h20 : 8'(8'h09 + r);
      end
      KIND_MARK: begin
        r = $urandom_range(0, 2);
        return (r == 0) ? MARK_PERIOD : (r == 1) ? MARK_QUESTION : MARK_BANG;
      end
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // One input transfer, with random idle cycles ahead of it.
  task automatic send_byte(input logic [7:0] code, input logic fin);
    in_item_t item;
    item.char_code  = code;
    item.final_char = fin;
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    sb.note_byte(item);
    bytes_sent++;
  endtask

  // Sender holds off until every predicted result has been received.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // A passage with given counts of letters, marks and whitespace in shuffled order.
  task automatic send_mix(input int n_let, input int n_mark, input int n_ws);
    logic [7:0] text[$];
    logic [7:0] tmp;
    int j;
    for (int i = 0; i < n_let; i++) text.push_back(pick_byte(KIND_LETTER));
    for (int i = 0; i < n_mark; i++) text.push_back(pick_byte(KIND_MARK));
    for (int i = 0; i < n_ws; i++) text.push_back(pick_byte(KIND_SPACE));
    for (int i = text.size() - 1; i > 0; i--) begin
      j       = $urandom_range(0, i);
      tmp     = text[i];
      text[i] = text[j];
      text[j] = tmp;
    end
    for (int i = 0; i < text.size(); i++) send_byte(text[i], i == text.size() - 1);
  endtask

  // A random passage; most are short, a few run longer.
  task automatic send_random_passage();
    int len, let_pct, ws_pct, mark_pct, r;
    byte_kind_t kind;
    len      = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 60) : $urandom_range(1, 16);
    let_pct  = $urandom_range(10, 80);
    ws_pct   = $urandom_range(5, 25);
    mark_pct = $urandom_range(0, 15);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (r < let_pct) kind = KIND_LETTER;
      else if (r < let_pct + ws_pct) kind = KIND_SPACE;
      else if (r < let_pct + ws_pct + mark_pct) kind = KIND_MARK;
      else kind = KIND_ANY;
      send_byte(pick_byte(kind), i == len - 1);
    end
  endtask

  // Result side: sample at each edge, then pick the next ready value.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) sb.check_result(out_data);
      out_ready <= ($urandom_range(0, 99) >= recv_stall);
    end
  end

  // Stimulus and end of run.
  initial begin
    logic [7:0] border_codes[25];
    int passages;
    border_codes = '{8'h00, 8'h08, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h1F,
                     8'h20, 8'h21, 8'h2E, 8'h3F, 8'h40, 8'h41, 8'h5A, 8'h5B, 8'h60,
                     8'h61, 8'h7A, 8'h7B, 8'h7F, 8'h80, 8'hFF, 8'h3F};
    sb         = new();
    send_idle  = 0;
    recv_stall = 0;
    bytes_sent = 0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Empty passage, and a final byte that is itself counted.
    send_byte(8'h00, 1'b1);
    send_byte("A", 1'b1);
    // Every class border, non-ASCII bytes, and a mark as the final byte.
    for (int i = 0; i < 25; i++) send_byte(border_codes[i], i == 24);
    // Ties away from zero, negative and positive.
    send_mix(5, 3, 1);
    send_mix(15, 1, 1);
    send_mix(55, 3, 1);
    // Band edges at index 1, 2, 15 and 16.
    send_mix(13, 2, 0);
    send_mix(3, 0, 0);
    send_mix(21, 0, 3);
    send_mix(16, 0, 2);
    hold_until_drained();

    // Random passages under four idling mixes.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 59; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 59; end
        default: begin send_idle = 35; recv_stall = 35; end
      endcase
      bytes_sent = 0;
      passages   = 0;
      while (bytes_sent < 55 || passages < 5) begin
        send_random_passage();
        passages++;
      end
      hold_until_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("readability_index_counter verification clean");
    end else begin
      $display("readability_index_counter verification failed");
    end
    $finish;
  end
endmodule

// File: sim.f
rtl/core/rdx_pkg.sv
rtl/core/rdx_front.sv
rtl/core/rdx_fifo.sv
rtl/core/rdx_back.sv
rtl/core/readability_index_counter.sv
sim/tb_readability_index_counter.sv
